// File: rtl/symbol_front_coding_encoder_assert.svh
// assertion macros for the checker of the encoder
`ifndef SYMBOL_FRONT_CODING_ENCODER_ASSERT_SVH
`define SYMBOL_FRONT_CODING_ENCODER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SFCE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfce assertion failed");

// next-cycle implication, clocked on i_clk, off during reset
`define SFCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfce assertion failed");

`endif

// File: rtl/sfce_pkg.sv
package sfce_pkg;

    localparam int NameDepth   = 63;
    localparam int PrefixLimit = 63;
    localparam int PosW        = 6;
    localparam int MaxResults  = 4;
    localparam int CntW        = 3;
    localparam int RdW         = 2;

    typedef enum logic [1:0] {
        MODE_ABS  = 2'b00,
        MODE_BACK = 2'b01,
        MODE_FWD  = 2'b10,
        MODE_FAR  = 2'b11
    } t_mode;

    typedef struct packed {
        logic [7:0]  name_char;
        logic [15:0] symbol_address;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       symbol_done;
    } t_out;

endpackage

// File: rtl/symbol_front_coding_encoder.sv
// Front-coding encoder for a name-sorted symbol list. Name bytes enter one per transfer,
// each name ending in a NUL, with the symbol address sampled on the first byte. Leading
// bytes shared with the previous name (up to 63) produce no output; the first unshared
// byte produces the attribute byte (shared count in bits 5..0, address mode in bits 7..6)
// followed by that byte, and the NUL additionally produces one offset byte or two absolute
// address bytes, low byte first. Each accepted input byte loads its results into a small
// result buffer of up to four bytes that drains one byte per cycle while the output is not
// stalled, so an input transfer is taken each cycle while at most one buffered byte remains
// and is not stalled. A shared byte produces no result, others one to four. The previous-name
// store is 63 bytes with per-entry valid flags, so it is usable right after reset.
module symbol_front_coding_encoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sfce_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sfce_pkg::t_out  o_out_data
);

    logic [7:0]                    r_name_mem [sfce_pkg::NameDepth];
    logic [sfce_pkg::NameDepth-1:0] r_name_vld;
    logic [7:0]                    r_mem_q;
    logic [sfce_pkg::PosW-1:0]     r_pos;
    logic                          r_pfx_done;
    logic [15:0]                   r_prev_addr;
    logic [15:0]                   r_lat_addr;
    sfce_pkg::t_out                r_buf [sfce_pkg::MaxResults];
    logic [sfce_pkg::CntW-1:0]     r_cnt;
    logic [sfce_pkg::RdW-1:0]      r_rd;

    logic [sfce_pkg::PosW-1:0]     n_pos;
    logic                          n_pfx_done;

    logic [7:0]                    w_char;
    logic                          w_first;
    logic [15:0]                   w_lat;
    logic [16:0]                   w_diff;
    sfce_pkg::t_mode               w_mode;
    logic [7:0]                    w_ofs;
    logic                          w_in_lim;
    logic                          w_in_depth;
    logic                          w_match;
    logic                          w_end;
    logic                          w_acc;
    logic                          w_we;
    logic                          w_xfer;
    logic                          w_rd_ok;
    sfce_pkg::t_out                w_res [sfce_pkg::MaxResults];
    logic [sfce_pkg::CntW-1:0]     w_n;

    assign w_char     = i_in_data.name_char;
    assign w_first    = (r_pos == '0) && !r_pfx_done;
    assign w_lat      = w_first ? i_in_data.symbol_address : r_lat_addr;
    assign w_diff     = {1'b0, w_lat} - {1'b0, r_prev_addr};
    assign w_in_depth = r_pos < sfce_pkg::PosW'(sfce_pkg::NameDepth);
    assign w_in_lim   = (r_pos < sfce_pkg::PosW'(sfce_pkg::PrefixLimit)) && w_in_depth;
    assign w_end      = (w_char == 8'd0);
    assign w_match    = !r_pfx_done && !w_end && w_in_lim && (r_mem_q == w_char);

    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_buf[r_rd];
    assign w_xfer      = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_cnt > sfce_pkg::CntW'(1)) ||
                         ((r_cnt == sfce_pkg::CntW'(1)) && i_out_stall);
    assign w_acc       = i_in_valid && !o_in_stall;
    assign w_we        = w_acc && !w_match && w_in_depth;
    assign w_rd_ok     = n_pos < sfce_pkg::PosW'(sfce_pkg::NameDepth);

    // address mode from the signed distance to the previous address
    always_comb begin
        if (w_diff[16:8] == '1) begin
            w_mode = sfce_pkg::MODE_BACK;
            w_ofs  = ~w_diff[7:0];
        end else if (w_diff[16:8] == 9'd0) begin
            w_mode = sfce_pkg::MODE_FWD;
            w_ofs  = w_diff[7:0];
        end else if (w_diff[16:8] == 9'd1) begin
            w_mode = sfce_pkg::MODE_FAR;
            w_ofs  = w_diff[7:0];
        end else begin
            w_mode = sfce_pkg::MODE_ABS;
            w_ofs  = 8'd0;
        end
    end

    // result list for this byte
    always_comb begin
        w_n = '0;
        for (int k = 0; k < sfce_pkg::MaxResults; k++) begin
            w_res[k] = '0;
        end
        if (!w_match) begin
            if (!r_pfx_done) begin
                w_res[w_n[sfce_pkg::RdW-1:0]] = '{out_byte: {w_mode, r_pos}, symbol_done: 1'b0};
                w_n = w_n + sfce_pkg::CntW'(1);
            end
            w_res[w_n[sfce_pkg::RdW-1:0]] = '{out_byte: w_char, symbol_done: 1'b0};
            w_n = w_n + sfce_pkg::CntW'(1);
            if (w_end) begin
                if (w_mode == sfce_pkg::MODE_ABS) begin
                    w_res[w_n[sfce_pkg::RdW-1:0]] =
                        '{out_byte: w_lat[7:0], symbol_done: 1'b0};
                    w_n = w_n + sfce_pkg::CntW'(1);
                    w_res[w_n[sfce_pkg::RdW-1:0]] =
                        '{out_byte: w_lat[15:8], symbol_done: 1'b1};
                    w_n = w_n + sfce_pkg::CntW'(1);
                end else begin
                    w_res[w_n[sfce_pkg::RdW-1:0]] = '{out_byte: w_ofs, symbol_done: 1'b1};
                    w_n = w_n + sfce_pkg::CntW'(1);
                end
            end
        end
    end

    always_comb begin
        n_pos      = r_pos;
        n_pfx_done = r_pfx_done;
        if (w_acc) begin
            if (w_match) begin
                n_pos = r_pos + sfce_pkg::PosW'(1);
            end else if (w_end) begin
                n_pos      = '0;
                n_pfx_done = 1'b0;
            end else begin
                n_pfx_done = 1'b1;
                if (w_in_depth) begin
                    n_pos = r_pos + sfce_pkg::PosW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_name_mem[r_pos] <= w_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (w_n != '0)) begin
            for (int k = 0; k < sfce_pkg::MaxResults; k++) begin
                r_buf[k] <= w_res[k];
            end
        end
        if (w_acc && w_first) begin
            r_lat_addr <= i_in_data.symbol_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_vld  <= '0;
            r_mem_q     <= 8'd0;
            r_pos       <= '0;
            r_pfx_done  <= 1'b0;
            r_prev_addr <= 16'd0;
            r_cnt       <= '0;
            r_rd        <= '0;
        end else begin
            // registered read of the previous name at the next position, write-first
            if (w_rd_ok && w_we && (r_pos == n_pos)) begin
                r_mem_q <= w_char;
            end else if (w_rd_ok && r_name_vld[n_pos]) begin
                r_mem_q <= r_name_mem[n_pos];
            end else begin
                r_mem_q <= 8'd0;
            end
            r_pos      <= n_pos;
            r_pfx_done <= n_pfx_done;
            if (w_we) begin
                r_name_vld[r_pos] <= 1'b1;
            end
            if (w_acc && !w_match && w_end) begin
                r_prev_addr <= w_lat;
            end
            if (w_acc && (w_n != '0)) begin
                r_cnt <= w_n;
                r_rd  <= '0;
            end else if (w_xfer) begin
                r_cnt <= r_cnt - sfce_pkg::CntW'(1);
                r_rd  <= r_rd + sfce_pkg::RdW'(1);
            end
        end
    end

endmodule

// File: rtl/sfce_checker.sv
`include "symbol_front_coding_encoder_assert.svh"

module sfce_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_stall,
    input sfce_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_stall,
    input sfce_pkg::t_out o_out_data
);

    // a stalled result stays and holds its payload
    `SFCE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // a stalled input transfer stays and holds its payload
    `SFCE_ASSERT_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_data))
    // input is only held back by pending results
    `SFCE_ASSERT_SAME(a_stall_needs_result, o_in_stall, o_out_valid)
    // a blocked result keeps the input from overrunning the buffer
    `SFCE_ASSERT_SAME(a_blocked_stalls_input, o_out_valid && i_out_stall, o_in_stall)

endmodule

bind symbol_front_coding_encoder sfce_checker u_sfce_checker (.*);

// File: bench/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfce_pkg::*;

    typedef logic [7:0] t_name_q[$];

    localparam int CycleLimit = 400000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_in    i_in_data = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    t_out   o_out_data;

    // encoder state mirror
    logic [7:0]  last_name [NameDepth];
    int          name_pos = 0;
    bit          attr_sent = 1'b0;
    logic [15:0] prev_sym_addr = '0;
    logic [15:0] cur_sym_addr = '0;
    t_out        expected_bytes[$];

    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int items_sent = 0;
    int mismatch_count = 0;
    int cycle_count = 0;

    // stimulus history
    t_name_q     sent_name;
    logic [15:0] sent_addr = '0;

    symbol_front_coding_encoder DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < NameDepth; i++) begin
            last_name[i] = 8'h00;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
    end

    function automatic t_mode address_mode_of(output logic [7:0] offset_byte);
        int off;
        off = int'(cur_sym_addr) - int'(prev_sym_addr);
        offset_byte = 8'h00;
        if (off < -256 || off > 511) begin
            return MODE_ABS;
        end
        if (off < 0) begin
            offset_byte = 8'(-off - 1);
            return MODE_BACK;
        end
        if (off < 256) begin
            offset_byte = 8'(off);
            return MODE_FWD;
        end
        offset_byte = 8'(off - 256);
        return MODE_FAR;
    endfunction

    task automatic push_expected(input logic [7:0] b, input logic done);
        t_out e;
        e.out_byte = b;
        e.symbol_done = done;
        expected_bytes.push_back(e);
    endtask

    task automatic encode_byte(input t_in item);
        logic [7:0] c;
        logic [7:0] ob;
        t_mode      mode;
        c = item.name_char;
        if (name_pos == 0 && !attr_sent) begin
            cur_sym_addr = item.symbol_address;
        end
        if (!attr_sent) begin
            if (c != 8'h00 && name_pos < PrefixLimit && last_name[name_pos] == c) begin
                name_pos++;
                return;
            end
            attr_sent = 1'b1;
            mode = address_mode_of(ob);
            push_expected({mode, 6'(name_pos)}, 1'b0);
        end
        push_expected(c, 1'b0);
        if (name_pos < NameDepth) begin
            last_name[name_pos] = c;
            name_pos++;
        end
        if (c == 8'h00) begin
            mode = address_mode_of(ob);
            if (mode == MODE_ABS) begin
                push_expected(cur_sym_addr[7:0], 1'b0);
                push_expected(cur_sym_addr[15:8], 1'b1);
            end else begin
                push_expected(ob, 1'b1);
            end
            prev_sym_addr = cur_sym_addr;
            name_pos = 0;
            attr_sent = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t: %s got %02h expected %02h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // input transfers are predicted before the output of the same edge is checked
    always @(posedge i_clk) begin : check_output
        t_out want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            encode_byte(i_in_data);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_bytes.size() == 0) begin
                report_mismatch("unexpected transfer", o_out_data.out_byte, 8'h00);
            end else begin
                want = expected_bytes.pop_front();
                if (o_out_data.out_byte !== want.out_byte) begin
                    report_mismatch("out_byte", o_out_data.out_byte, want.out_byte);
                end
                if (o_out_data.symbol_done !== want.symbol_done) begin
                    report_mismatch("symbol_done", 8'(o_out_data.symbol_done),
                                    8'(want.symbol_done));
                end
            end
        end
    end

    task automatic send_char(input t_in item);
        while (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        items_sent++;
    endtask

    // address only matters on the first byte, later bytes carry noise
    task automatic send_name(input t_name_q nm, input logic [15:0] addr);
        t_in item;
        for (int i = 0; i <= nm.size(); i++) begin
            item.name_char = (i < nm.size()) ? nm[i] : 8'h00;
            item.symbol_address = (i == 0) ? addr : 16'($urandom);
            send_char(item);
        end
        sent_name = nm;
        sent_addr = addr;
    endtask

    task automatic send_text(input string s, input logic [15:0] addr);
        t_name_q nm;
        for (int i = 0; i < s.len(); i++) begin
            nm.push_back(s[i]);
        end
        send_name(nm, addr);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);
    endtask

    task automatic test_address_modes();
        t_name_q nm;
        send_text("", 16'h0000);
        send_text("a", 16'h00FF);
        send_text("ab", 16'h01FF);
        send_text("ab", 16'h03FE);
        send_text("ac", 16'h02FE);
        send_text("b", 16'h02FD);
        nm.push_back(8'h62);
        nm.push_back(8'hFF);
        send_name(nm, 16'h04FD);
        send_text("", 16'h03FC);
        nm = {};
        nm.push_back(8'h01);
        send_name(nm, 16'hFFFF);
        send_name(nm, 16'h0000);
        wait_drained();
    endtask

    task automatic test_long_names();
        t_name_q nm;
        t_name_q part;
        for (int i = 0; i < 66; i++) begin
            nm.push_back(8'($urandom_range(1, 255)));
        end
        send_name(nm, 16'h1234);
        send_name(nm, 16'h1300);
        part = nm[0:39];
        for (int i = 0; i < 5; i++) begin
            part.push_back(8'($urandom_range(1, 255)));
        end
        send_name(part, 16'h8000);
        wait_drained();
    endtask

    task automatic test_random(input int n_items);
        int      boundary_offsets[8] = '{-257, -256, -1, 0, 255, 256, 511, 512};
        t_name_q nm;
        int      len;
        int      share;
        int      stop_at;
        logic [15:0] addr;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            nm = {};
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 68) : $urandom_range(0, 10);
            share = 0;
            if ($urandom_range(3) != 0) begin
                share = $urandom_range(0, (len < sent_name.size()) ? len : sent_name.size());
            end
            for (int i = 0; i < len; i++) begin
                if (i < share) begin
                    nm.push_back(sent_name[i]);
                end else begin
                    nm.push_back(8'($urandom_range(1, 255)));
                end
            end
            case ($urandom_range(3))
                0: begin
                    addr = sent_addr + 16'($urandom_range(0, 511));
                end
                1: begin
                    addr = sent_addr - 16'($urandom_range(1, 256));
                end
                2: begin
                    addr = sent_addr + 16'(boundary_offsets[$urandom_range(7)]);
                end
                default: begin
                    addr = 16'($urandom);
                end
            endcase
            send_name(nm, addr);
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_address_modes();

        in_gap_pct = 20;
        out_stall_pct = 20;
        test_long_names();

        in_gap_pct = 0;
        out_stall_pct = 0;
        test_random(25);

        in_gap_pct = 87;
        out_stall_pct = 0;
        test_random(25);

        in_gap_pct = 0;
        out_stall_pct = 87;
        test_random(25);

        in_gap_pct = 20;
        out_stall_pct = 20;
        test_random(25);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/sfce_pkg.sv
rtl/symbol_front_coding_encoder.sv
rtl/sfce_checker.sv
bench/tb_top.sv
